@@ rtl/flash_program_erase_controller_macros.svh @@
// Assertion macros shared by the flash program and erase controller RTL
`ifndef FLASH_PROGRAM_ERASE_CONTROLLER_MACROS_SVH
`define FLASH_PROGRAM_ERASE_CONTROLLER_MACROS_SVH
`ifndef ASSERT_OFF
`define FPE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define FPE_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define FPE_ASSERT(lbl, clk, rst_n, prop)
`define FPE_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

@@ rtl/fpe_pkg.sv @@
// Constants and codes of the flash program and erase controller
`timescale 1ns / 1ps
package fpe_pkg;
    localparam int unsigned FLASH_DEPTH = 32768;
    localparam int          FLASH_AW    = 15;

    localparam logic [31:0] KEY_ONE     = 32'h4567_0123;
    localparam logic [31:0] KEY_TWO     = 32'hCDEF_89AB;
    localparam logic [31:0] FLASH_BASE  = 32'h0800_0000;
    localparam logic [7:0]  RDP_DEFAULT = 8'hA5;
    localparam logic [7:0]  DATA_DEFAULT = 8'hFF;
    localparam logic [15:0] CELL_ERASED = 16'hFFFF;

    localparam logic [2:0] CMD_REG_READ    = 3'd0;
    localparam logic [2:0] CMD_REG_WRITE   = 3'd1;
    localparam logic [2:0] CMD_FLASH_WRITE = 3'd2;
    localparam logic [2:0] CMD_FLASH_READ  = 3'd3;
    localparam logic [2:0] CMD_OPT_WRITE   = 3'd4;

    localparam logic [2:0] REG_KEY       = 3'd0;
    localparam logic [2:0] REG_OPT_KEY   = 3'd1;
    localparam logic [2:0] REG_STATUS    = 3'd2;
    localparam logic [2:0] REG_CONTROL   = 3'd3;
    localparam logic [2:0] REG_ADDRESS   = 3'd4;
    localparam logic [2:0] REG_OPT_BYTES = 3'd5;

    localparam logic [2:0] OPT_RDP   = 3'd0;
    localparam logic [2:0] OPT_DATA0 = 3'd2;
    localparam logic [2:0] OPT_DATA1 = 3'd3;

    localparam int CR_PG     = 0;
    localparam int CR_PER    = 1;
    localparam int CR_OPTPG  = 4;
    localparam int CR_OPTER  = 5;
    localparam int CR_STRT   = 6;
    localparam int CR_LOCK   = 7;
    localparam int CR_OPTWRE = 9;
    localparam int SR_PGERR  = 2;
    localparam int SR_EOP    = 5;

    localparam int MODE_PG    = 0;
    localparam int MODE_PER   = 1;
    localparam int MODE_OPTPG = 2;
    localparam int MODE_OPTER = 3;
endpackage

@@ rtl/flash_program_erase_controller.sv @@
// Top level of the flash program and erase controller
`timescale 1ns / 1ps
`include "flash_program_erase_controller_macros.svh"
// After reset the block sweeps the 32768-entry flash array to all ones, one half-word a
// cycle, and holds busy high for the whole sweep. A bus access is then taken when start
// is high and busy is low; it is registered, run in the execute state, and its result is
// registered onto the result ports with done high for one cycle only, and cannot be held
// off. Busy is low again while done is high; the read-then-write of the single flash RAM
// port means no access is taken before the last is done. A control write that starts an
// in-range page erase keeps busy high through page-number calculation and a walk of the
// page's PAGE_BYTES/2 half-words through the same RAM port, one half-word a cycle.
module flash_program_erase_controller #(
    parameter int PAGE_BYTES  = 1024,
    parameter int FLASH_PAGES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    output logic        done,
    input  logic [2:0]  command,
    input  logic [2:0]  reg_select,
    input  logic [14:0] flash_offset,
    input  logic [2:0]  option_index,
    input  logic [31:0] write_data,
    output logic [31:0] read_data,
    output logic        access_fault
);
    localparam int HALF   = PAGE_BYTES / 2;
    localparam int SPAN   = FLASH_PAGES * PAGE_BYTES;
    localparam int PAGE_W = (FLASH_PAGES > 1) ? $clog2(FLASH_PAGES) : 1;
    localparam int CNT_W  = $clog2(HALF);
    localparam int EW     = $clog2(SPAN / 2);
    localparam int WALK_W = (EW > fpe_pkg::FLASH_AW) ? EW : fpe_pkg::FLASH_AW;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_EXEC  = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_ERASE = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic        locked_reg, locked_next;
    logic        key_reg, key_next;
    logic        okey_reg, okey_next;
    logic        owe_reg, owe_next;
    logic [3:0]  mode_reg, mode_next;
    logic        end_reg, end_next;
    logic        perr_reg, perr_next;
    logic [31:0] addr_reg, addr_next;
    logic [7:0]  rdp_reg, rdp_next;
    logic [7:0]  data0_reg, data0_next;
    logic [7:0]  data1_reg, data1_next;
    logic [WALK_W-1:0] walk_reg, walk_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic        done_reg, done_next;

    logic [2:0]  cmd_reg, cmd_next;
    logic [2:0]  sel_reg, sel_next;
    logic [14:0] off_reg, off_next;
    logic [2:0]  oix_reg, oix_next;
    logic [31:0] data_reg, data_next;
    logic [31:0] rd_reg, rd_next;
    logic        fault_reg, fault_next;

    logic                         ram_we;
    logic [fpe_pkg::FLASH_AW-1:0] ram_addr;
    logic [15:0]                  ram_wdata;
    logic [15:0]                  ram_rdata;

    logic              div_load;
    logic              div_done;
    logic [PAGE_W-1:0] div_page;
    logic [31:0]       erase_offset;
    logic              erase_in_range;

    assign erase_offset   = addr_reg - fpe_pkg::FLASH_BASE;
    assign erase_in_range = (addr_reg >= fpe_pkg::FLASH_BASE) && (erase_offset < 32'(SPAN));

    fpe_ram #(
        .WIDTH (16),
        .DEPTH (fpe_pkg::FLASH_DEPTH)
    ) u_flash_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    fpe_page_div #(
        .PAGE_BYTES  (PAGE_BYTES),
        .FLASH_PAGES (FLASH_PAGES)
    ) u_page_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (div_load),
        .offset (erase_offset),
        .done   (div_done),
        .page   (div_page)
    );

    always_comb
    begin
        logic owe_v;
        owe_v       = owe_reg;
        state_next  = state_reg;
        locked_next = locked_reg;
        key_next    = key_reg;
        okey_next   = okey_reg;
        owe_next    = owe_reg;
        mode_next   = mode_reg;
        end_next    = end_reg;
        perr_next   = perr_reg;
        addr_next   = addr_reg;
        rdp_next    = rdp_reg;
        data0_next  = data0_reg;
        data1_next  = data1_reg;
        walk_next   = walk_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        cmd_next    = cmd_reg;
        sel_next    = sel_reg;
        off_next    = off_reg;
        oix_next    = oix_reg;
        data_next   = data_reg;
        rd_next     = rd_reg;
        fault_next  = fault_reg;
        ram_we      = 1'b0;
        ram_addr    = flash_offset;
        ram_wdata   = fpe_pkg::CELL_ERASED;
        div_load    = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_addr  = walk_reg[fpe_pkg::FLASH_AW-1:0];
                walk_next = walk_reg + 1'b1;
                if (walk_reg == WALK_W'(fpe_pkg::FLASH_DEPTH - 1))
                begin
                    walk_next  = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = command;
                    sel_next   = reg_select;
                    off_next   = flash_offset;
                    oix_next   = option_index;
                    data_next  = write_data;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                ram_addr   = off_reg;
                state_next = ST_IDLE;
                done_next  = 1'b1;
                rd_next    = '0;
                fault_next = 1'b0;
                case (cmd_reg)
                    fpe_pkg::CMD_REG_READ:
                    begin
                        case (sel_reg)
                            fpe_pkg::REG_STATUS:
                                rd_next = {26'b0, end_reg, 2'b0, perr_reg, 2'b0};
                            fpe_pkg::REG_CONTROL:
                                rd_next = {22'b0, owe_reg, 1'b0, locked_reg, 1'b0,
                                           mode_reg[3:2], 2'b0, mode_reg[1:0]};
                            fpe_pkg::REG_ADDRESS:
                                rd_next = addr_reg;
                            fpe_pkg::REG_OPT_BYTES:
                                rd_next = {6'b0, data1_reg, data0_reg, 8'b0,
                                           (rdp_reg != fpe_pkg::RDP_DEFAULT), 1'b0};
                            default:
                                rd_next = '0;
                        endcase
                    end
                    fpe_pkg::CMD_REG_WRITE:
                    begin
                        case (sel_reg)
                            fpe_pkg::REG_KEY:
                            begin
                                if (locked_reg)
                                begin
                                    if (key_reg && data_reg == fpe_pkg::KEY_TWO)
                                    begin
                                        locked_next = 1'b0;
                                        key_next    = 1'b0;
                                    end
                                    else
                                    begin
                                        key_next = !key_reg && (data_reg == fpe_pkg::KEY_ONE);
                                    end
                                end
                            end
                            fpe_pkg::REG_OPT_KEY:
                            begin
                                if (locked_reg)
                                begin
                                    fault_next = 1'b1;
                                end
                                else if (okey_reg && data_reg == fpe_pkg::KEY_TWO)
                                begin
                                    owe_next  = 1'b1;
                                    okey_next = 1'b0;
                                end
                                else
                                begin
                                    okey_next = !okey_reg && (data_reg == fpe_pkg::KEY_ONE);
                                end
                            end
                            fpe_pkg::REG_STATUS:
                            begin
                                if (data_reg[fpe_pkg::SR_EOP])
                                begin
                                    end_next = 1'b0;
                                end
                                if (data_reg[fpe_pkg::SR_PGERR])
                                begin
                                    perr_next = 1'b0;
                                end
                            end
                            fpe_pkg::REG_CONTROL:
                            begin
                                if (locked_reg)
                                begin
                                    fault_next = 1'b1;
                                end
                                else
                                begin
                                    mode_next = {data_reg[fpe_pkg::CR_OPTER],
                                                 data_reg[fpe_pkg::CR_OPTPG],
                                                 data_reg[fpe_pkg::CR_PER],
                                                 data_reg[fpe_pkg::CR_PG]};
                                    owe_v = owe_reg && data_reg[fpe_pkg::CR_OPTWRE];
                                    if (data_reg[fpe_pkg::CR_STRT])
                                    begin
                                        if (data_reg[fpe_pkg::CR_PER])
                                        begin
                                            end_next = 1'b1;
                                            if (erase_in_range)
                                            begin
                                                div_load   = 1'b1;
                                                state_next = ST_DIV;
                                            end
                                        end
                                        else if (data_reg[fpe_pkg::CR_OPTER])
                                        begin
                                            if (owe_v)
                                            begin
                                                rdp_next   = fpe_pkg::RDP_DEFAULT;
                                                data0_next = fpe_pkg::DATA_DEFAULT;
                                                data1_next = fpe_pkg::DATA_DEFAULT;
                                                end_next   = 1'b1;
                                            end
                                            else
                                            begin
                                                fault_next = 1'b1;
                                            end
                                        end
                                    end
                                    if (data_reg[fpe_pkg::CR_LOCK])
                                    begin
                                        locked_next = 1'b1;
                                        owe_v       = 1'b0;
                                        key_next    = 1'b0;
                                        okey_next   = 1'b0;
                                    end
                                    owe_next = owe_v;
                                end
                            end
                            fpe_pkg::REG_ADDRESS:
                                addr_next = data_reg;
                            default:
                            begin
                            end
                        endcase
                    end
                    fpe_pkg::CMD_FLASH_WRITE:
                    begin
                        if (locked_reg || !mode_reg[fpe_pkg::MODE_PG])
                        begin
                            fault_next = 1'b1;
                        end
                        else if (ram_rdata == fpe_pkg::CELL_ERASED)
                        begin
                            ram_we    = 1'b1;
                            ram_wdata = data_reg[15:0];
                            end_next  = 1'b1;
                        end
                        else
                        begin
                            perr_next = 1'b1;
                        end
                    end
                    fpe_pkg::CMD_FLASH_READ:
                        rd_next = {16'b0, ram_rdata};
                    fpe_pkg::CMD_OPT_WRITE:
                    begin
                        if (locked_reg || !mode_reg[fpe_pkg::MODE_OPTPG] || !owe_reg)
                        begin
                            fault_next = 1'b1;
                        end
                        else
                        begin
                            case (oix_reg)
                                fpe_pkg::OPT_RDP:
                                begin
                                    rdp_next = data_reg[7:0];
                                    end_next = 1'b1;
                                end
                                fpe_pkg::OPT_DATA0:
                                begin
                                    data0_next = data_reg[7:0];
                                    end_next   = 1'b1;
                                end
                                fpe_pkg::OPT_DATA1:
                                begin
                                    data1_next = data_reg[7:0];
                                    end_next   = 1'b1;
                                end
                                default:
                                begin
                                end
                            endcase
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    walk_next  = WALK_W'(32'(div_page) * 32'(HALF));
                    cnt_next   = '0;
                    state_next = ST_ERASE;
                end
            end
            ST_ERASE:
            begin
                ram_addr  = walk_reg[fpe_pkg::FLASH_AW-1:0];
                ram_we    = (32'(walk_reg) < fpe_pkg::FLASH_DEPTH);
                walk_next = walk_reg + 1'b1;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(HALF - 1))
                begin
                    walk_next  = '0;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            locked_reg <= 1'b1;
            key_reg    <= 1'b0;
            okey_reg   <= 1'b0;
            owe_reg    <= 1'b0;
            mode_reg   <= '0;
            end_reg    <= 1'b0;
            perr_reg   <= 1'b0;
            addr_reg   <= '0;
            rdp_reg    <= fpe_pkg::RDP_DEFAULT;
            data0_reg  <= fpe_pkg::DATA_DEFAULT;
            data1_reg  <= fpe_pkg::DATA_DEFAULT;
            walk_reg   <= '0;
            cnt_reg    <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            locked_reg <= locked_next;
            key_reg    <= key_next;
            okey_reg   <= okey_next;
            owe_reg    <= owe_next;
            mode_reg   <= mode_next;
            end_reg    <= end_next;
            perr_reg   <= perr_next;
            addr_reg   <= addr_next;
            rdp_reg    <= rdp_next;
            data0_reg  <= data0_next;
            data1_reg  <= data1_next;
            walk_reg   <= walk_next;
            cnt_reg    <= cnt_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        sel_reg   <= sel_next;
        off_reg   <= off_next;
        oix_reg   <= oix_next;
        data_reg  <= data_next;
        rd_reg    <= rd_next;
        fault_reg <= fault_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign read_data    = rd_reg;
    assign access_fault = fault_reg;

    `FPE_ASSERT(a_accept_to_done, clk, rst_n, (start && !busy) |=> ##1 done)
    `FPE_ASSERT(a_done_after_exec, clk, rst_n, done |-> $past(state_reg == ST_EXEC))
    `FPE_ASSERT(a_program_on_erased, clk, rst_n, (ram_we && state_reg == ST_EXEC) |-> (ram_rdata == fpe_pkg::CELL_ERASED))
    `FPE_ASSERT(a_fault_reads_zero, clk, rst_n, (done && access_fault) |-> (read_data == '0))
    `FPE_ASSERT_NEVER(a_no_write_when_idle, clk, rst_n, ram_we && state_reg == ST_IDLE)
endmodule

@@ rtl/fpe_ram.sv @@
// Generic single-port synchronous RAM with registered read
`timescale 1ns / 1ps
module fpe_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32768
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

@@ rtl/fpe_page_div.sv @@
// Page number of an in-range erase offset, by multiplication with the page-size reciprocal
`timescale 1ns / 1ps
module fpe_page_div #(
    parameter int PAGE_BYTES  = 1024,
    parameter int FLASH_PAGES = 64,
    localparam int PAGE_W = (FLASH_PAGES > 1) ? $clog2(FLASH_PAGES) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  logic [31:0]       offset,
    output logic              done,
    output logic [PAGE_W-1:0] page
);
    localparam int SPAN    = FLASH_PAGES * PAGE_BYTES;
    localparam int NUM_W   = $clog2(SPAN);
    localparam int SHIFT   = NUM_W + $clog2(PAGE_BYTES);
    localparam int RECIP_W = NUM_W + 2;
    localparam int PROD_W  = NUM_W + RECIP_W;
    localparam logic [63:0] RECIP =
        ((64'd1 << SHIFT) + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES);

    logic              calc_reg, calc_next;
    logic              done_reg, done_next;
    logic [NUM_W-1:0]  num_reg, num_next;
    logic [PAGE_W-1:0] page_reg, page_next;
    logic [PROD_W-1:0] product;

    assign product   = PROD_W'(num_reg) * PROD_W'(RECIP);

    assign calc_next = load;
    assign done_next = calc_reg;
    assign num_next  = load ? offset[NUM_W-1:0] : num_reg;
    assign page_next = calc_reg ? product[SHIFT +: PAGE_W] : page_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calc_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            calc_reg <= calc_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        page_reg <= page_next;
    end

    assign done = done_reg;
    assign page = page_reg;
endmodule
